@@ rtl/core/rsla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsla_pkg: shared types and constants of the record slot list allocator
// Widths, result codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rsla_pkg;

	localparam int ID_W             = 11;
	localparam int STATUS_W         = 2;
	localparam int DEFAULT_CAPACITY = 1024;
	// Largest id that the slot_id field can carry.
	localparam int MAX_ID           = (1 << ID_W) - 1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		RES_DONE   = 2'd0,
		RES_REJECT = 2'd1,
		RES_BEYOND = 2'd2
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_GROW_LINK,
		S_GROW,
		S_READ,
		S_UNLINK,
		S_PUSH_A,
		S_PUSH_B
	} fsm_state_t;

	typedef struct packed {
		logic    load;
		logic    read;
		logic    grow_link;
		logic    grow_step;
		logic    unlink;
		logic    push_a;
		logic    push_b;
		logic    finish;
		result_t result;
	} dp_cmd_t;

	typedef struct packed {
		logic id_zero;
		logic id_over;
		logic op_delete;
		logic need_grow;
		logic grow_last;
		logic slot_free;
	} dp_stat_t;

endpackage

@@ rtl/core/record_slot_list_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_slot_list_allocator: claims and releases numbered record slots
// Slots are kept on a doubly linked in-use list and a doubly linked free
// list, both held in link memories. The store grows on demand up to the
// claimed id, pushing every new slot onto the free list.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                        Handshake
// --------  -------------------------------------------  ----------------------
// command   operation, slot_id                            start high, busy low
// result    status, reported_used_head,                   done high, one cycle
//           reported_free_head, reported_slot_count
//
// A claim or release of an existing slot keeps the block busy through a
// check that also reads the slot's links, an unlink, and two push writes.
// Each is a dependent read-modify-write on the single write port of the
// link memories. A claim past the slots made so far adds a link step, a
// growth step per new slot (one new slot per cycle) and a reread. A zero
// id, an id past capacity or a release of an unmade slot returns from the
// check; a slot in the wrong list is rejected at the unlink (plus growth).
// The done strobe is high in the first cycle in which busy is low again; the
// receiver cannot stall, and a new command beat may be taken in that cycle.
// Reset clears the count and both heads at once. The link memories need no
// clearing pass: an entry is only used after its slot has been created.
// ----------------------------------------------------------------------------
module record_slot_list_allocator #(
	parameter int CAPACITY = rsla_pkg::DEFAULT_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [rsla_pkg::ID_W-1:0]     slot_id,
	output logic                          done,
	output logic [rsla_pkg::STATUS_W-1:0] status,
	output logic [rsla_pkg::ID_W-1:0]     reported_used_head,
	output logic [rsla_pkg::ID_W-1:0]     reported_free_head,
	output logic [rsla_pkg::ID_W-1:0]     reported_slot_count
);

	// Commands flow from the controller to the datapath; the datapath
	// reports id checks, the growth end and the slot's free bit back.
	rsla_pkg::dp_cmd_t  cmd;
	rsla_pkg::dp_stat_t stat;

	rsla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the link memories, the heads, the slot count and
	// the result register that drives the result beat.
	rsla_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.operation           (operation),
		.slot_id             (slot_id),
		.stat                (stat),
		.done                (done),
		.status              (status),
		.reported_used_head  (reported_used_head),
		.reported_free_head  (reported_free_head),
		.reported_slot_count (reported_slot_count)
	);

endmodule

@@ rtl/core/rsla_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsla_ctrl: sequencing controller
// Steps one beat through check, growth, unlink and push phases.
// ----------------------------------------------------------------------------
module rsla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rsla_pkg::dp_stat_t stat,
	output rsla_pkg::dp_cmd_t  cmd,
	output logic               busy
);

	rsla_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsla_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsla_pkg::S_IDLE: begin
				if (start) state_d = rsla_pkg::S_CHECK;
			end
			rsla_pkg::S_CHECK: begin
				if (stat.id_zero || stat.id_over) begin
					state_d = rsla_pkg::S_IDLE;
				end else if (stat.need_grow) begin
					state_d = stat.op_delete ? rsla_pkg::S_IDLE : rsla_pkg::S_GROW_LINK;
				end else begin
					state_d = rsla_pkg::S_UNLINK;
				end
			end
			rsla_pkg::S_GROW_LINK: state_d = rsla_pkg::S_GROW;
			rsla_pkg::S_GROW: begin
				if (stat.grow_last) state_d = rsla_pkg::S_READ;
			end
			rsla_pkg::S_READ: state_d = rsla_pkg::S_UNLINK;
			rsla_pkg::S_UNLINK: begin
				// Only a slot in the opposite list may move.
				if (stat.slot_free == stat.op_delete) begin
					state_d = rsla_pkg::S_IDLE;
				end else begin
					state_d = rsla_pkg::S_PUSH_A;
				end
			end
			rsla_pkg::S_PUSH_A: state_d = rsla_pkg::S_PUSH_B;
			rsla_pkg::S_PUSH_B: state_d = rsla_pkg::S_IDLE;
			default: state_d = rsla_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.result = rsla_pkg::RES_DONE;
		unique case (state_q)
			rsla_pkg::S_IDLE: begin
				cmd.load = start;
			end
			rsla_pkg::S_CHECK: begin
				cmd.read = 1'b1;
				if (stat.id_zero) begin
					cmd.finish = 1'b1;
					cmd.result = rsla_pkg::RES_REJECT;
				end else if (stat.id_over) begin
					cmd.finish = 1'b1;
					cmd.result = rsla_pkg::RES_BEYOND;
				end else if (stat.need_grow && stat.op_delete) begin
					cmd.finish = 1'b1;
					cmd.result = rsla_pkg::RES_REJECT;
				end
			end
			rsla_pkg::S_GROW_LINK: cmd.grow_link = 1'b1;
			rsla_pkg::S_GROW:      cmd.grow_step = 1'b1;
			rsla_pkg::S_READ:      cmd.read      = 1'b1;
			rsla_pkg::S_UNLINK: begin
				if (stat.slot_free == stat.op_delete) begin
					cmd.finish = 1'b1;
					cmd.result = rsla_pkg::RES_REJECT;
				end else begin
					cmd.unlink = 1'b1;
				end
			end
			rsla_pkg::S_PUSH_A: cmd.push_a = 1'b1;
			rsla_pkg::S_PUSH_B: begin
				cmd.push_b = 1'b1;
				cmd.finish = 1'b1;
				cmd.result = rsla_pkg::RES_DONE;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != rsla_pkg::S_IDLE);

endmodule

@@ rtl/core/rsla_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsla_dp: list datapath
// Link memories, head and count registers, and the result register.
// ----------------------------------------------------------------------------
module rsla_dp #(
	parameter int CAPACITY = rsla_pkg::DEFAULT_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsla_pkg::dp_cmd_t             cmd,
	input  logic                          operation,
	input  logic [rsla_pkg::ID_W-1:0]     slot_id,
	output rsla_pkg::dp_stat_t            stat,
	output logic                          done,
	output logic [rsla_pkg::STATUS_W-1:0] status,
	output logic [rsla_pkg::ID_W-1:0]     reported_used_head,
	output logic [rsla_pkg::ID_W-1:0]     reported_free_head,
	output logic [rsla_pkg::ID_W-1:0]     reported_slot_count
);

	localparam int IW    = rsla_pkg::ID_W;
	// Slots that an id of the field width can reach.
	localparam int SLOTS = (CAPACITY < rsla_pkg::MAX_ID) ? CAPACITY : rsla_pkg::MAX_ID;
	localparam int AW    = $clog2(SLOTS + 1);
	localparam logic [16:0] CAP_L = 17'(CAPACITY);

	logic [IW-1:0] prev_mem [SLOTS+1];
	logic [IW-1:0] next_mem [SLOTS+1];
	logic          free_mem [SLOTS+1];

	logic          op_q;
	logic [IW-1:0] id_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] used_head_q;
	logic [IW-1:0] free_head_q;
	logic [IW-1:0] prev_rd_q;
	logic [IW-1:0] next_rd_q;
	logic          free_rd_q;
	logic          done_q;
	rsla_pkg::result_t status_q;

	logic [IW-1:0] new_slot;
	logic [IW-1:0] tgt_head;

	logic          prev_we, next_we, free_we;
	logic [AW-1:0] prev_wa, next_wa, free_wa;
	logic [IW-1:0] prev_wd, next_wd;
	logic          free_wd;

	assign new_slot = count_q + IW'(1);
	assign tgt_head = op_q ? free_head_q : used_head_q;

	assign stat.id_zero   = (id_q == '0);
	assign stat.id_over   = ({6'b0, id_q} > CAP_L);
	assign stat.op_delete = (op_q == rsla_pkg::OP_DELETE);
	assign stat.need_grow = (id_q > count_q);
	assign stat.grow_last = (new_slot == id_q);
	assign stat.slot_free = free_rd_q;

	always_comb begin
		prev_we = 1'b0;
		next_we = 1'b0;
		free_we = 1'b0;
		prev_wa = id_q[AW-1:0];
		next_wa = id_q[AW-1:0];
		free_wa = id_q[AW-1:0];
		prev_wd = '0;
		next_wd = '0;
		free_wd = 1'b0;
		if (cmd.grow_link) begin
			prev_we = (free_head_q != '0);
			prev_wa = free_head_q[AW-1:0];
			prev_wd = new_slot;
		end else if (cmd.grow_step) begin
			// The following slot becomes this one's predecessor, except the last.
			prev_we = 1'b1;
			prev_wa = new_slot[AW-1:0];
			prev_wd = stat.grow_last ? '0 : new_slot + IW'(1);
			next_we = 1'b1;
			next_wa = new_slot[AW-1:0];
			next_wd = free_head_q;
			free_we = 1'b1;
			free_wa = new_slot[AW-1:0];
			free_wd = 1'b1;
		end else if (cmd.unlink) begin
			next_we = (prev_rd_q != '0);
			next_wa = prev_rd_q[AW-1:0];
			next_wd = next_rd_q;
			prev_we = (next_rd_q != '0);
			prev_wa = next_rd_q[AW-1:0];
			prev_wd = prev_rd_q;
			free_we = 1'b1;
			free_wd = op_q;
		end else if (cmd.push_a) begin
			prev_we = 1'b1;
			prev_wd = '0;
			next_we = 1'b1;
			next_wd = tgt_head;
		end else if (cmd.push_b) begin
			prev_we = (tgt_head != '0);
			prev_wa = tgt_head[AW-1:0];
			prev_wd = id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (cmd.read) prev_rd_q <= prev_mem[id_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (cmd.read) next_rd_q <= next_mem[id_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_wa] <= free_wd;
		if (cmd.read) free_rd_q <= free_mem[id_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			id_q <= slot_id;
		end
		if (cmd.finish) status_q <= cmd.result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			used_head_q <= '0;
			free_head_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.grow_step) begin
				count_q     <= new_slot;
				free_head_q <= new_slot;
			end
			if (cmd.unlink && (prev_rd_q == '0)) begin
				if (op_q == rsla_pkg::OP_DELETE) used_head_q <= next_rd_q;
				else free_head_q <= next_rd_q;
			end
			if (cmd.push_b) begin
				if (op_q == rsla_pkg::OP_DELETE) free_head_q <= id_q;
				else used_head_q <= id_q;
			end
		end
	end

	assign done                = done_q;
	assign status              = status_q;
	assign reported_used_head  = used_head_q;
	assign reported_free_head  = free_head_q;
	assign reported_slot_count = count_q;

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("slot count went down");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{6'b0, count_q} <= CAP_L)
		else $error("slot count beyond capacity");

	a_heads_created: assert property (@(posedge clk) disable iff (!arst_n)
		(used_head_q <= count_q) && (free_head_q <= count_q))
		else $error("list head names a slot not yet created");

	a_grow_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grow_step |-> (count_q < id_q))
		else $error("growth stepped past the requested id");

	a_one_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.grow_link, cmd.grow_step, cmd.unlink, cmd.push_a, cmd.push_b}))
		else $error("more than one link update in a cycle");

endmodule

@@ test/record_slot_list_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_slot_list_allocator_tb: self-checking bench for the slot allocator
// Drives claims and releases through the start/busy handshake and checks
// each done beat against a behavioral mirror of both slot lists or a row's
// hand-typed want. A short table of directed commands comes first, then
// about 1650 random commands that grow the store step by step and churn both lists.
// ----------------------------------------------------------------------------
module record_slot_list_allocator_tb;

	localparam int ID_W         = rsla_pkg::ID_W;
	localparam int CAPACITY     = rsla_pkg::DEFAULT_CAPACITY;
	localparam int RANDOM_BEATS = 1650;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 10;
	localparam int ROW_COUNT    = 24;

	// One result beat as the block reports it.
	typedef struct packed {
		rsla_pkg::result_t status;
		logic [ID_W-1:0]   used_head;
		logic [ID_W-1:0]   free_head;
		logic [ID_W-1:0]   slot_count;
	} slot_report_t;

	// One row of the directed table. Rows with has_want set carry an
	// expectation typed in by hand; the others are left to the mirror.
	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] id;
		logic            has_want;
		slot_report_t    want;
	} cmd_row_t;

	localparam slot_report_t NO_WANT = '0;

	localparam cmd_row_t DIRECTED_ROWS [ROW_COUNT] = '{
		// Every kind of rejection on an empty store leaves it untouched.
		'{rsla_pkg::OP_DELETE, 11'd5,    1'b1, '{rsla_pkg::RES_REJECT, 11'd0, 11'd0, 11'd0}},
		'{rsla_pkg::OP_INSERT, 11'd0,    1'b1, '{rsla_pkg::RES_REJECT, 11'd0, 11'd0, 11'd0}},
		'{rsla_pkg::OP_DELETE, 11'd0,    1'b1, '{rsla_pkg::RES_REJECT, 11'd0, 11'd0, 11'd0}},
		'{rsla_pkg::OP_INSERT, 11'd1025, 1'b1, '{rsla_pkg::RES_BEYOND, 11'd0, 11'd0, 11'd0}},
		'{rsla_pkg::OP_DELETE, 11'd2047, 1'b1, '{rsla_pkg::RES_BEYOND, 11'd0, 11'd0, 11'd0}},
		'{rsla_pkg::OP_DELETE, 11'd1024, 1'b1, '{rsla_pkg::RES_REJECT, 11'd0, 11'd0, 11'd0}},
		// A single slot: claim, double claim, release, double release.
		'{rsla_pkg::OP_INSERT, 11'd1,    1'b1, '{rsla_pkg::RES_DONE,   11'd1, 11'd0, 11'd1}},
		'{rsla_pkg::OP_INSERT, 11'd1,    1'b1, '{rsla_pkg::RES_REJECT, 11'd1, 11'd0, 11'd1}},
		'{rsla_pkg::OP_DELETE, 11'd1,    1'b1, '{rsla_pkg::RES_DONE,   11'd0, 11'd1, 11'd1}},
		'{rsla_pkg::OP_DELETE, 11'd1,    1'b1, '{rsla_pkg::RES_REJECT, 11'd0, 11'd1, 11'd1}},
		// Short growth, then unlinking at the head, middle and tail.
		'{rsla_pkg::OP_INSERT, 11'd3,    1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd1,    1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd2,    1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd3,    1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd1,    1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd2,    1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd1,    1'b0, NO_WANT},
		// A long growth walk, then wrong-state and out-of-range ids.
		'{rsla_pkg::OP_INSERT, 11'd300,  1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd2,    1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd300,  1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd299,  1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd2,    1'b0, NO_WANT},
		'{rsla_pkg::OP_INSERT, 11'd1536, 1'b0, NO_WANT},
		'{rsla_pkg::OP_DELETE, 11'd1000, 1'b0, NO_WANT}
	};

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic            operation;
	logic [ID_W-1:0] slot_id;
	logic            done;
	logic [rsla_pkg::STATUS_W-1:0] status;
	logic [ID_W-1:0] reported_used_head;
	logic [ID_W-1:0] reported_free_head;
	logic [ID_W-1:0] reported_slot_count;

	record_slot_list_allocator #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.operation          (operation),
		.slot_id            (slot_id),
		.done               (done),
		.status             (status),
		.reported_used_head (reported_used_head),
		.reported_free_head (reported_free_head),
		.reported_slot_count(reported_slot_count)
	);

	// 10 ns clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Mirror of the allocator. It keeps its own copy of both link memories,
	// the free flags, the slot count and the two list heads. Entries are
	// indexed by slot number, so index 0 (the "none" link) is never stored.
	// ------------------------------------------------------------------------
	logic [ID_W-1:0] mirror_back  [1:CAPACITY];
	logic [ID_W-1:0] mirror_fwd   [1:CAPACITY];
	bit              mirror_free  [1:CAPACITY];
	logic [ID_W-1:0] mirror_count;
	logic [ID_W-1:0] mirror_used_head;
	logic [ID_W-1:0] mirror_free_head;

	slot_report_t pending_reports [$];
	int           error_count;
	int           cycle_count;
	bit           steady_sender;

	// Take slot s out of whichever list head points into.
	function automatic void list_remove(input logic [ID_W-1:0] s,
			inout logic [ID_W-1:0] head);
		logic [ID_W-1:0] p;
		logic [ID_W-1:0] n;
		p = mirror_back[s];
		n = mirror_fwd[s];
		if (p != '0)
			mirror_fwd[p] = n;
		else
			head = n;
		if (n != '0)
			mirror_back[n] = p;
	endfunction

	// Make slot s the new head of the list.
	function automatic void list_push(input logic [ID_W-1:0] s,
			inout logic [ID_W-1:0] head);
		mirror_back[s] = '0;
		mirror_fwd[s]  = head;
		if (head != '0)
			mirror_back[head] = s;
		head = s;
	endfunction

	// Apply one claim or release to the mirror and return the beat it yields.
	function automatic slot_report_t apply_command(input logic op,
			input logic [ID_W-1:0] id);
		rsla_pkg::result_t res;
		if (id == '0) begin
			res = rsla_pkg::RES_REJECT;
		end else if (id > CAPACITY) begin
			res = rsla_pkg::RES_BEYOND;
		end else if (op == rsla_pkg::OP_INSERT) begin
			// Grow one slot at a time; each new slot lands on the free list.
			while (mirror_count < id) begin
				mirror_count++;
				mirror_free[mirror_count] = 1'b1;
				list_push(mirror_count, mirror_free_head);
			end
			if (!mirror_free[id]) begin
				res = rsla_pkg::RES_REJECT;
			end else begin
				mirror_free[id] = 1'b0;
				list_remove(id, mirror_free_head);
				list_push(id, mirror_used_head);
				res = rsla_pkg::RES_DONE;
			end
		end else begin
			if (id > mirror_count || mirror_free[id]) begin
				res = rsla_pkg::RES_REJECT;
			end else begin
				mirror_free[id] = 1'b1;
				list_remove(id, mirror_used_head);
				list_push(id, mirror_free_head);
				res = rsla_pkg::RES_DONE;
			end
		end
		return '{res, mirror_used_head, mirror_free_head, mirror_count};
	endfunction

	// Find an existing slot that is free (want_free) or in use. Up to 16 random
	// probes are tried first so that slots deep inside a list get picked; the
	// list head is the fallback. Returns 0 if that list is empty.
	function automatic logic [ID_W-1:0] find_slot(input bit want_free);
		logic [ID_W-1:0] probe;
		if (mirror_count != '0) begin
			for (int t = 0; t < 16; t++) begin
				probe = ID_W'($urandom_range(1, mirror_count));
				if (mirror_free[probe] == want_free)
					return probe;
			end
		end
		return want_free ? mirror_free_head : mirror_used_head;
	endfunction

	// ------------------------------------------------------------------------
	// Random command mix. Most beats are well-formed claims of free slots and
	// releases of used ones, so that both lists keep getting relinked. About
	// one beat in seven grows the store by a few slots (now and then by a few
	// dozen), which fills it to capacity part way through the run. The rest
	// is noise: zero ids, ids past capacity, wrong-state and unmade slots.
	// ------------------------------------------------------------------------
	task automatic pick_random(output logic op, output logic [ID_W-1:0] id);
		int roll;
		int span;
		roll = $urandom_range(0, 99);
		op   = ($urandom_range(0, 1) != 0) ? rsla_pkg::OP_DELETE : rsla_pkg::OP_INSERT;
		id   = '0;
		if (roll < 40) begin
			op = rsla_pkg::OP_INSERT;
			id = find_slot(1'b1);
		end else if (roll < 70) begin
			op = rsla_pkg::OP_DELETE;
			id = find_slot(1'b0);
		end
		// An empty list above falls through to growth.
		if (id != '0)
			return;
		if (roll < 85) begin
			op = rsla_pkg::OP_INSERT;
			if (mirror_count < CAPACITY) begin
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
					: $urandom_range(1, 6);
				id = (int'(mirror_count) + span > CAPACITY) ? ID_W'(CAPACITY)
					: ID_W'(int'(mirror_count) + span);
			end else begin
				id = ID_W'($urandom_range(1, CAPACITY));
			end
		end else if (roll < 89) begin
			id = '0;
		end else if (roll < 93) begin
			id = ID_W'($urandom_range(CAPACITY + 1, rsla_pkg::MAX_ID));
		end else if (roll < 97) begin
			// Wrong list: claim a used slot or release a free one.
			id = find_slot(op == rsla_pkg::OP_DELETE);
			if (id == '0)
				id = ID_W'($urandom_range(0, rsla_pkg::MAX_ID));
		end else begin
			op = rsla_pkg::OP_DELETE;
			id = (mirror_count < CAPACITY)
				? ID_W'($urandom_range(int'(mirror_count) + 1, CAPACITY))
				: ID_W'($urandom_range(0, rsla_pkg::MAX_ID));
		end
	endtask

	// Mostly short gaps, a few long ones; none at all while steady_sender is set.
	function automatic int pick_gap();
		int roll;
		if (steady_sender)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// Present one command beat and hold it until the block takes it. Entered
	// and left at a falling edge; start stays high across back-to-back beats.
	task automatic send_command(input logic op, input logic [ID_W-1:0] id,
			input logic has_want, input slot_report_t want);
		int gap;
		slot_report_t predicted;
		slot_report_t expected;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		slot_id   = id;
		start     = 1'b1;
		// The beat is taken at the first rising edge that sees busy low.
		do
			@(posedge clk);
		while (busy);
		predicted = apply_command(op, id);
		expected  = has_want ? want : predicted;
		pending_reports.insert(pending_reports.size(), expected);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result checker. Every done beat must match the oldest expectation; the
	// receiver cannot stall, so each beat is looked at exactly once.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		slot_report_t want;
		slot_report_t seen;
		if (arst_n && done) begin
			seen = '{rsla_pkg::result_t'(status), reported_used_head, reported_free_head,
				reported_slot_count};
			if (pending_reports.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("%0t: result beat with none expected: status %0d used %0d free %0d count %0d",
						$realtime, seen.status, seen.used_head, seen.free_head,
						seen.slot_count);
			end else begin
				want = pending_reports.pop_front();
				if (seen.status != want.status || seen.used_head != want.used_head
						|| seen.free_head != want.free_head
						|| seen.slot_count != want.slot_count) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("%0t: mismatch: status %0d/%0d used %0d/%0d free %0d/%0d count %0d/%0d (expected/actual)",
							$realtime, want.status, seen.status, want.used_head,
							seen.used_head, want.free_head, seen.free_head,
							want.slot_count, seen.slot_count);
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed table, random traffic, drain, verdict.
	// ------------------------------------------------------------------------
	initial begin
		logic            op;
		logic [ID_W-1:0] id;
		start            = 1'b0;
		operation        = rsla_pkg::OP_INSERT;
		slot_id          = '0;
		arst_n           = 1'b0;
		error_count      = 0;
		cycle_count      = 0;
		steady_sender    = 1'b0;
		mirror_count     = '0;
		mirror_used_head = '0;
		mirror_free_head = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < ROW_COUNT; r++)
			send_command(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].id,
				DIRECTED_ROWS[r].has_want, DIRECTED_ROWS[r].want);

		for (int k = 0; k < RANDOM_BEATS; k++) begin
			// Now and then run a stretch of beats with no sender gaps at all.
			if (k % 64 == 0)
				steady_sender = ($urandom_range(0, 99) < 30);
			pick_random(op, id);
			send_command(op, id, 1'b0, NO_WANT);
		end
		start = 1'b0;

		// Wait out the last beats, then a little longer to catch strays.
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
